// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define AST_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// expression must never be true outside reset
`define AST_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define AST_HOLDS(lbl, clk, rst_n, prop)
`define AST_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== sv/smpq_pkg.sv =====
// types and codes of the sorted max priority queue
`default_nettype none
package smpq_pkg;

    localparam int SYM_W = 8;
    localparam int WT_W  = 32;
    localparam int OCC_W = 9;

    // operation kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    // one queue entry
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [WT_W-1:0]  wt;
    } t_entry;

    // contents of one cell
    typedef struct packed {
        logic   vld;
        t_entry ent;
    } t_slot;

    // command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry ent;
    } t_cmd;

    // one result item
    typedef struct packed {
        t_status          status;
        t_entry           out;
        logic [OCC_W-1:0] occ;
        logic [WT_W-1:0]  top_wt;
        logic             empty;
    } t_result;

endpackage
`default_nettype wire

// ===== sv/smpq_cell.sv =====
// one storage cell of the sorted shift chain
`default_nettype none
module smpq_cell (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_head,
    input  smpq_pkg::t_cmd   i_cmd,
    input  wire              i_left_keep,
    input  smpq_pkg::t_slot  i_left,
    input  smpq_pkg::t_slot  i_right,
    output logic             o_keep,
    output smpq_pkg::t_slot  o_slot
);
    import smpq_pkg::*;

    logic  r_vld;
    t_entry r_ent;
    logic  n_vld;
    t_entry n_ent;

    // entry stays put on insert when its weight is larger, or equal in the head cell
    assign o_keep = r_vld && ((r_ent.wt > i_cmd.ent.wt) ||
                              (i_head && (r_ent.wt == i_cmd.ent.wt)));

    // next contents: keep, take new entry, shift from left or from right
    always_comb begin
        n_vld = r_vld;
        n_ent = r_ent;
        if (i_cmd.ins && !o_keep) begin
            if (i_left_keep) begin
                n_vld = 1'b1;
                n_ent = i_cmd.ent;
            end else begin
                n_vld = i_left.vld;
                n_ent = i_left.ent;
            end
        end else if (i_cmd.rem) begin
            n_vld = i_right.vld;
            n_ent = i_right.ent;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_slot.vld = r_vld;
    assign o_slot.ent = r_ent;

endmodule
`default_nettype wire

// ===== sv/sorted_max_priority_queue_unit.sv =====
// sorted max priority queue built from a chain of shifting cells
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  input   | in        | i_valid / o_stall  | i_kind, i_symbol, i_weight
//  result  | out       | o_valid / i_stall  | o_status, o_out_symbol, o_out_weight,
//          |           |                    | o_occupancy, o_top_weight, o_is_empty
//
// one item per cycle while o_stall is low: every cell compares the new weight against
// its own entry in parallel and shifts by one place, so an insert or remove is applied
// to the whole chain at once. each result is registered in the output register, or in
// the skid stage while a result is stalled, which lets one more item in; then o_stall
// rises. reset clears the fill count, the cell valid flags and both output stages.
`default_nettype none
`include "assert_macros.svh"
module sorted_max_priority_queue_unit #(
    parameter int CAPACITY = 256
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire                          i_kind,
    input  wire  [smpq_pkg::SYM_W-1:0]   i_symbol,
    input  wire  [smpq_pkg::WT_W-1:0]    i_weight,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [1:0]                   o_status,
    output logic [smpq_pkg::SYM_W-1:0]   o_out_symbol,
    output logic [smpq_pkg::WT_W-1:0]    o_out_weight,
    output logic [smpq_pkg::OCC_W-1:0]   o_occupancy,
    output logic [smpq_pkg::WT_W-1:0]    o_top_weight,
    output logic                         o_is_empty
);
    import smpq_pkg::*;

    localparam int FILL_W = $clog2(CAPACITY + 1);

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              r_out_vld;
    logic              n_out_vld;
    logic              r_skid_vld;
    logic              n_skid_vld;
    t_result           r_out;
    t_result           n_out;
    t_result           r_skid;
    t_result           n_skid;
    t_result           w_res;
    t_cmd              w_cmd;
    t_slot             w_slot [CAPACITY];
    logic              w_keep [CAPACITY];
    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic              w_is_ins;
    t_slot             w_none;

    // input transfer and queue condition
    assign o_stall  = r_skid_vld;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_fill == FILL_W'(CAPACITY));
    assign w_empty  = (r_fill == '0);
    assign w_is_ins = (i_kind == KIND_INSERT);
    assign w_none   = '0;

    // command broadcast to the chain
    always_comb begin
        w_cmd.ins     = w_accept && w_is_ins && !w_full;
        w_cmd.rem     = w_accept && !w_is_ins && !w_empty;
        w_cmd.ent.sym = i_symbol;
        w_cmd.ent.wt  = i_weight;
    end

    // chain of cells, head at index 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_head
            smpq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_head      (1'b1),
                .i_cmd       (w_cmd),
                .i_left_keep (1'b1),
                .i_left      (w_none),
                .i_right     (w_slot[g+1]),
                .o_keep      (w_keep[g]),
                .o_slot      (w_slot[g])
            );
        end else if (g == CAPACITY - 1) begin : g_tail
            smpq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_head      (1'b0),
                .i_cmd       (w_cmd),
                .i_left_keep (w_keep[g-1]),
                .i_left      (w_slot[g-1]),
                .i_right     (w_none),
                .o_keep      (w_keep[g]),
                .o_slot      (w_slot[g])
            );
        end else begin : g_mid
            smpq_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_head      (1'b0),
                .i_cmd       (w_cmd),
                .i_left_keep (w_keep[g-1]),
                .i_left      (w_slot[g-1]),
                .i_right     (w_slot[g+1]),
                .o_keep      (w_keep[g]),
                .o_slot      (w_slot[g])
            );
        end
    end

    // result of the incoming item and the new fill count
    always_comb begin
        n_fill     = r_fill;
        w_res      = '0;
        w_res.status = ST_OK;
        if (w_is_ins) begin
            if (w_full) begin
                w_res.status = ST_OVER;
                w_res.top_wt = w_slot[0].ent.wt;
            end else begin
                n_fill = r_fill + FILL_W'(1);
                if (w_empty || (i_weight > w_slot[0].ent.wt)) begin
                    w_res.top_wt = i_weight;
                end else begin
                    w_res.top_wt = w_slot[0].ent.wt;
                end
            end
        end else begin
            if (w_empty) begin
                w_res.status = ST_UNDER;
            end else begin
                n_fill    = r_fill - FILL_W'(1);
                w_res.out = w_slot[0].ent;
                if (r_fill > FILL_W'(1)) begin
                    w_res.top_wt = w_slot[1].ent.wt;
                end
            end
        end
        w_res.occ   = OCC_W'(n_fill);
        w_res.empty = (n_fill == '0);
    end

    // output register with skid stage
    always_comb begin
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        n_skid     = r_skid;
        n_skid_vld = r_skid_vld;
        if (!r_out_vld || !i_stall) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_out     = w_res;
                n_out_vld = w_accept;
            end
        end else if (w_accept) begin
            n_skid     = w_res;
            n_skid_vld = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_fill     <= w_accept ? n_fill : r_fill;
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // output ports
    assign o_valid      = r_out_vld;
    assign o_status     = r_out.status;
    assign o_out_symbol = r_out.out.sym;
    assign o_out_weight = r_out.out.wt;
    assign o_occupancy  = r_out.occ;
    assign o_top_weight = r_out.top_wt;
    assign o_is_empty   = r_out.empty;

    // checks
    `AST_NEVER(a_skid_without_out, i_clk, i_rst_n, r_skid_vld && !r_out_vld)
    `AST_HOLDS(a_head_matches_fill, i_clk, i_rst_n, w_slot[0].vld == (r_fill != '0))
    `AST_HOLDS(a_tail_matches_full, i_clk, i_rst_n, w_slot[CAPACITY-1].vld == w_full)
    `AST_NEVER(a_head_order, i_clk, i_rst_n,
               w_slot[0].vld && w_slot[1].vld && (w_slot[0].ent.wt < w_slot[1].ent.wt))

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the sorted max priority queue unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smpq_pkg::*;

    localparam int QCAP       = 256;
    localparam int N_ITEMS    = 1750;
    localparam int WDOG_LIMIT = 4000;
    localparam int HOLD_LEN   = 80;
    localparam int MAX_PRINTS = 40;

    // one pending input transfer
    typedef struct packed {
        logic             kind;
        logic [SYM_W-1:0] sym;
        logic [WT_W-1:0]  wt;
    } t_op;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             i_valid   = 1'b0;
    logic             i_kind    = KIND_INSERT;
    logic [SYM_W-1:0] i_symbol  = '0;
    logic [WT_W-1:0]  i_weight  = '0;
    logic             i_stall   = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [1:0]       o_status;
    logic [SYM_W-1:0] o_out_symbol;
    logic [WT_W-1:0]  o_out_weight;
    logic [OCC_W-1:0] o_occupancy;
    logic [WT_W-1:0]  o_top_weight;
    logic             o_is_empty;

    sorted_max_priority_queue_unit #(
        .CAPACITY (QCAP)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_symbol     (i_symbol),
        .i_weight     (i_weight),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_out_symbol (o_out_symbol),
        .o_out_weight (o_out_weight),
        .o_occupancy  (o_occupancy),
        .o_top_weight (o_top_weight),
        .o_is_empty   (o_is_empty)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_op             op_queue[$];
    t_result         pending_results[$];
    int              plan_fill  = 0;
    logic [WT_W-1:0] last_wt    = '0;
    int              mismatches = 0;

    // shadow copy of the queue contents, head in slot 0
    logic [SYM_W-1:0] q_sym [QCAP];
    logic [WT_W-1:0]  q_wt  [QCAP];
    int               q_fill = 0;

    // idle percentage per phase: sender busy then receiver busy then free running
    function automatic int idle_pct(int done, bit rx_side);
        if (done < N_ITEMS / 3) begin
            return rx_side ? 76 : 27;
        end else if (done < 2 * N_ITEMS / 3) begin
            return rx_side ? 27 : 76;
        end
        return 0;
    endfunction

    // apply one operation to the shadow queue and return the result it yields
    function automatic t_result apply_queue_op(logic kind, logic [SYM_W-1:0] sym,
                                               logic [WT_W-1:0] wt);
        t_result r;
        int      p;
        int      i;
        r        = '0;
        r.status = ST_OK;
        if (kind == KIND_INSERT) begin
            if (q_fill >= QCAP) begin
                r.status = ST_OVER;
            end else begin
                // behind every larger weight; right after an equal head
                if (q_fill == 0 || wt > q_wt[0]) begin
                    p = 0;
                end else begin
                    p = 1;
                    while (p < q_fill && q_wt[p] > wt) p++;
                end
                for (i = q_fill; i > p; i--) begin
                    q_sym[i] = q_sym[i-1];
                    q_wt[i]  = q_wt[i-1];
                end
                q_sym[p] = sym;
                q_wt[p]  = wt;
                q_fill++;
            end
        end else if (q_fill == 0) begin
            r.status = ST_UNDER;
        end else begin
            r.out.sym = q_sym[0];
            r.out.wt  = q_wt[0];
            for (i = 0; i < q_fill - 1; i++) begin
                q_sym[i] = q_sym[i+1];
                q_wt[i]  = q_wt[i+1];
            end
            q_fill--;
        end
        r.occ    = OCC_W'(q_fill);
        r.top_wt = (q_fill > 0) ? q_wt[0] : '0;
        r.empty  = (q_fill == 0);
        return r;
    endfunction

    // weights biased toward ties and both ends of the range
    function automatic logic [WT_W-1:0] rand_weight();
        logic [WT_W-1:0] w;
        case ($urandom_range(0, 3))
            0: w = WT_W'($urandom_range(0, 15));
            1: w = $urandom;
            2: w = ~WT_W'($urandom_range(0, 15));
            default: w = last_wt;
        endcase
        last_wt = w;
        return w;
    endfunction

    // append one operation and track the planned fill level
    task automatic add_op(logic kind, logic [SYM_W-1:0] sym, logic [WT_W-1:0] wt);
        t_op op;
        op.kind = kind;
        op.sym  = sym;
        op.wt   = wt;
        op_queue.push_back(op);
        if (kind == KIND_INSERT && plan_fill < QCAP) begin
            plan_fill++;
        end else if (kind == KIND_REMOVE && plan_fill > 0) begin
            plan_fill--;
        end
    endtask

    // fill to capacity, overflow a few times, then drain to empty
    task automatic fill_and_drain();
        int extra;
        extra = $urandom_range(1, 4);
        while (plan_fill < QCAP) add_op(KIND_INSERT, SYM_W'($urandom), rand_weight());
        repeat (extra) add_op(KIND_INSERT, SYM_W'($urandom), rand_weight());
        add_op(KIND_REMOVE, SYM_W'($urandom), $urandom);
        add_op(KIND_INSERT, SYM_W'($urandom), rand_weight());
        add_op(KIND_INSERT, SYM_W'($urandom), rand_weight());
        while (plan_fill > 0) begin
            add_op(($urandom_range(0, 99) < 85) ? KIND_REMOVE : KIND_INSERT,
                   SYM_W'($urandom), rand_weight());
        end
        add_op(KIND_REMOVE, SYM_W'($urandom), $urandom);
    endtask

    // driver: next item offered once the current one has transferred
    t_op drive_op;
    int  sent_cnt = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (op_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct(sent_cnt, 1'b0)) begin
                drive_op = op_queue.pop_front();
                sent_cnt++;
                i_valid  <= 1'b1;
                i_kind   <= drive_op.kind;
                i_symbol <= drive_op.sym;
                i_weight <= drive_op.wt;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off to back the block up
    int rx_count  = 0;
    int hold_left = 0;
    bit held_once = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) rx_count++;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!held_once && rx_count >= 200) begin
            held_once = 1'b1;
            hold_left = HOLD_LEN;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < idle_pct(rx_count, 1'b1));
        end
    end

    task automatic check_field(input string name, input logic [WT_W-1:0] want,
                               input logic [WT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_PRINTS) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endtask

    // monitor: check result transfers, then predict from input transfers
    t_result want_res;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_PRINTS) begin
                        $display("%0t: unexpected result, expected none, actual status %0h",
                                 $time, o_status);
                    end
                end else begin
                    want_res = pending_results.pop_front();
                    check_field("status", want_res.status, o_status);
                    check_field("out_symbol", want_res.out.sym, o_out_symbol);
                    check_field("out_weight", want_res.out.wt, o_out_weight);
                    check_field("occupancy", want_res.occ, o_occupancy);
                    check_field("top_weight", want_res.top_wt, o_top_weight);
                    check_field("is_empty", want_res.empty, o_is_empty);
                end
            end
            if (i_valid && !o_stall) begin
                pending_results.push_back(apply_queue_op(i_kind, i_symbol, i_weight));
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WDOG_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", idle_cycles);
                $display("sorted_max_priority_queue_unit regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        int seg_len;
        int ins_pct;
        int fills_done;
        fills_done = 0;

        // directed: underflow, ties at and below the head, extremes, drain
        add_op(KIND_REMOVE, 8'h00, 32'h0000_0000);
        add_op(KIND_INSERT, 8'hA5, 32'd100);
        add_op(KIND_INSERT, 8'h5A, 32'd100);
        add_op(KIND_INSERT, 8'h01, 32'd100);
        add_op(KIND_INSERT, 8'h02, 32'd50);
        add_op(KIND_INSERT, 8'h03, 32'd50);
        add_op(KIND_INSERT, 8'hFF, 32'hFFFF_FFFF);
        add_op(KIND_INSERT, 8'h00, 32'h0000_0000);
        add_op(KIND_INSERT, 8'h04, 32'h8000_0000);
        add_op(KIND_INSERT, 8'h05, 32'h7FFF_FFFF);
        repeat (10) add_op(KIND_REMOVE, 8'hFF, 32'hFFFF_FFFF);

        // random: mixed segments with two full fill and drain episodes
        while (op_queue.size() < N_ITEMS) begin
            if ((fills_done == 0 && op_queue.size() >= 400) ||
                (fills_done == 1 && op_queue.size() >= 1100)) begin
                fill_and_drain();
                fills_done++;
            end else begin
                seg_len = $urandom_range(8, 40);
                ins_pct = $urandom_range(20, 80);
                repeat (seg_len) begin
                    add_op(($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_REMOVE,
                           SYM_W'($urandom), rand_weight());
                end
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("sorted_max_priority_queue_unit regression: pass");
        end else begin
            $display("sorted_max_priority_queue_unit regression: fail");
        end
        $finish;
    end

endmodule
